/* sv/dtq_pkg.sv */
package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;           // timer slots in the chain
    localparam int MAX_RESULTS = 16;           // most releases per tick
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam int TIME_W   = 63;
    localparam int DELAY_W  = 31;
    localparam int HANDLE_W = 16;
    localparam int MS_TO_US = 1000;
    localparam int PROD_W   = DELAY_W + 10;    // delay_ms * 1000 < 2^41

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic REQ_SCHED    = 1'b0;
    localparam logic REQ_TICK     = 1'b1;
    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [DELAY_W-1:0]  delay_ms;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   now_time;
    } t_in_word;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] out_handle;
        logic                last;
    } t_out_word;

    // one slot of the sorted chain
    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   dl;
        logic [HANDLE_W-1:0] hdl;
    } t_entry;

    // chain-wide command, one of them per cycle at most
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_cmd;

endpackage

/* sv/dtq_cell.sv */
module dtq_cell import dtq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  logic [TIME_W-1:0]   i_new_dl,
    input  logic [HANDLE_W-1:0] i_new_handle,
    input  t_entry              i_prev,
    input  logic                i_prev_keep,
    input  t_entry              i_next,
    output t_entry              o_entry,
    output logic                o_keep
);

    logic                r_valid;
    logic [TIME_W-1:0]   r_dl;
    logic [HANDLE_W-1:0] r_hdl;

    // keep position on insert: equal deadlines stay ahead (FIFO order)
    assign o_keep  = r_valid && (r_dl <= i_new_dl);
    assign o_entry = '{valid: r_valid, dl: r_dl, hdl: r_hdl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins) begin
            r_valid <= r_valid | i_prev.valid;
        end else if (i_cmd.pop) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !o_keep) begin
            if (i_prev_keep) begin
                r_dl  <= i_new_dl;
                r_hdl <= i_new_handle;
            end else begin
                r_dl  <= i_prev.dl;
                r_hdl <= i_prev.hdl;
            end
        end else if (i_cmd.pop) begin
            r_dl  <= i_next.dl;
            r_hdl <= i_next.hdl;
        end
    end

endmodule

/* sv/deadline_timer_queue.sv */
// Channel   | Direction | Handshake                | Word
// ----------+-----------+--------------------------+-----------
// input     | in        | i_in_valid / o_in_ready  | t_in_word
// output    | out       | o_out_valid / i_out_ready| t_out_word
//
// Schedule: accept + multiply, add/saturate, insert into the chain.
// Rejection on a full queue: the reject word is registered in S_REJ once the output register is free.
// Tick: due timers are released from S_POP, one shift a cycle while the output is not stalled.
// Synchronous active-low reset empties the chain and zeroes the tick time.
// A stalled output holds the release loop; new words wait in IDLE only.
module deadline_timer_queue import dtq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out
);

    // controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_INS  = 5'b00100,
        S_REJ  = 5'b01000,
        S_POP  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [PROD_W-1:0]     r_prod;       // delay_ms * 1000
    logic [HANDLE_W-1:0]   r_handle;     // handle of word in flight
    logic [TIME_W-1:0]     r_dl;         // saturated deadline
    logic [TIME_W-1:0]     r_last_time;  // time of the latest tick
    logic [CNT_W-1:0]      r_cnt;        // releases so far on this tick
    logic                  r_out_valid;
    t_out_word             r_out;

    t_cell_cmd             w_cmd;
    t_entry                w_cell [QUEUE_DEPTH];
    logic                  w_keep [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_vvec;
    logic [TIME_W:0]       w_sum;
    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_full;
    logic                  w_head_due;
    logic                  w_next_due;
    logic                  w_last;
    logic                  w_emit_pop;

    // ------------------------------------------------------------------
    // Sorted chain: cell 0 holds the earliest deadline.
    // ------------------------------------------------------------------
    localparam t_entry HEAD_SRC = '{valid: 1'b1, dl: '0, hdl: '0};
    localparam t_entry TAIL_SRC = '{valid: 1'b0, dl: '0, hdl: '0};

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_keep;

        if (i == 0) begin : g_head
            assign w_prev      = HEAD_SRC;
            assign w_prev_keep = 1'b1;
        end else begin : g_mid
            assign w_prev      = w_cell[i-1];
            assign w_prev_keep = w_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = TAIL_SRC;
        end else begin : g_body
            assign w_next = w_cell[i+1];
        end

        dtq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new_dl     (r_dl),
            .i_new_handle (r_handle),
            .i_prev       (w_prev),
            .i_prev_keep  (w_prev_keep),
            .i_next       (w_next),
            .o_entry      (w_cell[i]),
            .o_keep       (w_keep[i])
        );

        assign w_vvec[i] = w_cell[i].valid;
    end

    // valid slots form a prefix, so the tail slot tells fullness
    assign w_full = w_cell[QUEUE_DEPTH-1].valid;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // deadline sum cannot pass 2^64, top bit flags saturation
    assign w_sum = {1'b0, r_last_time} + (TIME_W+1)'(r_prod);

    assign w_head_due = w_cell[0].valid && (w_cell[0].dl <= r_last_time);
    assign w_next_due = w_cell[1].valid && (w_cell[1].dl <= r_last_time);
    assign w_last     = !w_next_due || (r_cnt == CNT_W'(MAX_RESULTS - 1));
    assign w_emit_pop = (r_state == S_POP) && w_head_due && w_slot_free;

    assign w_cmd.ins = (r_state == S_INS);
    assign w_cmd.pop = w_emit_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.req_type == REQ_TICK) begin
                        n_state = S_POP;
                    end else if (w_full) begin
                        n_state = S_REJ;
                    end else begin
                        n_state = S_CALC;
                    end
                end
            end
            S_CALC: n_state = S_INS;
            S_INS:  n_state = S_IDLE;
            S_REJ: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (!w_head_due) begin
                    n_state = S_IDLE;           // nothing (more) due
                end else if (w_slot_free && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_time <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept && i_in.req_type == REQ_TICK) begin
                r_last_time <= i_in.now_time;
                r_cnt       <= '0;
            end else if (w_emit_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if ((r_state == S_REJ && w_slot_free) || w_emit_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod   <= PROD_W'(i_in.delay_ms) * PROD_W'(MS_TO_US);
            r_handle <= i_in.handle;
        end
        if (r_state == S_CALC) begin
            r_dl <= w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
        end
        if (r_state == S_REJ && w_slot_free) begin
            r_out <= '{kind: KIND_REJECT, out_handle: r_handle, last: 1'b1};
        end else if (w_emit_pop) begin
            r_out <= '{kind: KIND_EXPIRED, out_handle: w_cell[0].hdl, last: w_last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vvec & (w_vvec + QUEUE_DEPTH'(1))) == '0)
        else $error("chain valid bits are not a prefix");

    for (genvar k = 0; k < QUEUE_DEPTH - 1; k++) begin : g_chk_sort
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_cell[k+1].valid |-> (w_cell[k].dl <= w_cell[k+1].dl))
            else $error("chain out of deadline order");
    end

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> ($countones(w_vvec) == $past($countones(w_vvec)) + 1))
        else $error("insert did not add exactly one entry");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |=> ($countones(w_vvec) + 1 == $past($countones(w_vvec))))
        else $error("release did not remove exactly one entry");

endmodule

/* bench/deadline_timer_queue_tb.sv */
`timescale 1ns / 100ps

module deadline_timer_queue_tb;
    import dtq_pkg::*;

    localparam int N_RANDOM     = 405;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    deadline_timer_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // shadow of the sorted timer chain
    logic [TIME_W-1:0]   pend_dl  [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] pend_hdl [QUEUE_DEPTH];
    int                  pend_cnt = 0;
    logic [TIME_W-1:0]   tick_time = '0;

    t_in_word  timer_reqs[$];     // words not yet offered
    t_out_word due_words[$];      // predicted releases / rejections, oldest first

    int total_reqs   = 0;
    int accepted_cnt = 0;
    int fail_cnt     = 0;
    int cycle_cnt    = 0;
    bit draining     = 1'b0;

    // apply one accepted word to the shadow chain, queue what it releases
    task automatic apply_timer_req(input t_in_word w);
        logic [63:0] sum;
        t_out_word   r;
        int          pos;
        int          cnt;
        if (w.req_type == REQ_SCHED) begin
            if (pend_cnt >= QUEUE_DEPTH) begin
                r.kind       = KIND_REJECT;
                r.out_handle = w.handle;
                r.last       = 1'b1;
                due_words.push_back(r);
            end else begin
                sum = {1'b0, tick_time} + 64'(w.delay_ms) * 64'(MS_TO_US);
                if (sum > {1'b0, TIME_MAX})
                    sum = {1'b0, TIME_MAX};
                // equal deadlines go behind the ones already waiting
                pos = 0;
                while (pos < pend_cnt && pend_dl[pos] <= sum[TIME_W-1:0])
                    pos++;
                for (int i = pend_cnt; i > pos; i--) begin
                    pend_dl[i]  = pend_dl[i-1];
                    pend_hdl[i] = pend_hdl[i-1];
                end
                pend_dl[pos]  = sum[TIME_W-1:0];
                pend_hdl[pos] = w.handle;
                pend_cnt++;
            end
        end else begin
            tick_time = w.now_time;
            cnt = 0;
            while (cnt < pend_cnt && cnt < MAX_RESULTS && pend_dl[cnt] <= w.now_time)
                cnt++;
            for (int i = 0; i < cnt; i++) begin
                r.kind       = KIND_EXPIRED;
                r.out_handle = pend_hdl[i];
                r.last       = (i == cnt - 1);
                due_words.push_back(r);
            end
            for (int i = 0; i + cnt < pend_cnt; i++) begin
                pend_dl[i]  = pend_dl[i+cnt];
                pend_hdl[i] = pend_hdl[i+cnt];
            end
            pend_cnt -= cnt;
        end
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic logic [DELAY_W-1:0] rand_delay();
        logic [31:0] v;
        v = $urandom;
        return v[DELAY_W-1:0];
    endfunction

    function automatic logic [HANDLE_W-1:0] rand_handle();
        return HANDLE_W'($urandom_range(0, 65535));
    endfunction

    // unused fields carry random noise
    function automatic t_in_word sched_req(logic [DELAY_W-1:0] d, logic [HANDLE_W-1:0] h);
        t_in_word w;
        w.req_type = REQ_SCHED;
        w.delay_ms = d;
        w.handle   = h;
        w.now_time = rand_time();
        return w;
    endfunction

    function automatic t_in_word tick_req(logic [TIME_W-1:0] t);
        t_in_word w;
        w.req_type = REQ_TICK;
        w.delay_ms = rand_delay();
        w.handle   = rand_handle();
        w.now_time = t;
        return w;
    endfunction

    // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both
    function automatic int idle_phase();
        int p;
        p = (total_reqs == 0) ? 0 : accepted_cnt * 4 / total_reqs;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic bit sender_idle();
        case (idle_phase())
            1:       return $urandom_range(0, 99) < 58;
            3:       return $urandom_range(0, 99) < 31;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_phase())
            2:       return $urandom_range(0, 99) < 58;
            3:       return $urandom_range(0, 99) < 31;
            default: return 1'b0;
        endcase
    endfunction

    task automatic note_fail(input string msg);
        if (fail_cnt < MAX_REPORTS)
            $display("%s", msg);
        fail_cnt++;
    endtask

    // driver: offer the next word once the current one is taken
    always @(posedge i_clk) begin
        bit taken;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && in_ready;
            if (taken) begin
                apply_timer_req(in_word);
                accepted_cnt++;
            end
            if (!in_valid || taken) begin
                if (timer_reqs.size() > 0 && !sender_idle()) begin
                    in_word  <= timer_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each taken result word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (due_words.size() == 0) begin
                    note_fail($sformatf("unexpected word kind=%0d handle=%h last=%0d",
                                        out_word.kind, out_word.out_handle, out_word.last));
                end else begin
                    e = due_words.pop_front();
                    if (out_word.kind !== e.kind || out_word.out_handle !== e.out_handle ||
                        out_word.last !== e.last)
                        note_fail($sformatf(
                            "mismatch exp kind=%0d handle=%h last=%0d got kind=%0d handle=%h last=%0d",
                            e.kind, e.out_handle, e.last,
                            out_word.kind, out_word.out_handle, out_word.last));
                end
            end
            out_ready <= draining || !receiver_stall();
        end
    end

    always @(posedge i_clk)
        cycle_cnt++;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("deadline_timer_queue_tb NOT OK");
        $finish;
    end

    initial begin
        logic [TIME_W-1:0] sim_now;
        int                roll;
        int                burst;

        // directed: equal deadlines in order, backwards time, saturation,
        // full queue and a maximal release
        timer_reqs.push_back(sched_req('0, 16'h0000));
        timer_reqs.push_back(sched_req('0, 16'hFFFF));
        timer_reqs.push_back(sched_req(31'd1, 16'h1234));
        timer_reqs.push_back(tick_req(63'd999));             // two due
        timer_reqs.push_back(tick_req(63'd500));             // backwards, none due
        timer_reqs.push_back(sched_req({DELAY_W{1'b1}}, 16'hAAAA));
        timer_reqs.push_back(tick_req(TIME_MAX - 63'd5));
        timer_reqs.push_back(sched_req({DELAY_W{1'b1}}, 16'h5555)); // saturates
        timer_reqs.push_back(sched_req('0, 16'h0001));
        for (int i = 0; i < QUEUE_DEPTH - 2; i++)
            timer_reqs.push_back(sched_req(DELAY_W'($urandom_range(1, 32'h7FFF_FFFF)),
                                           16'h0100 + HANDLE_W'(i)));
        timer_reqs.push_back(sched_req(rand_delay(), 16'hBEEF)); // full
        timer_reqs.push_back(tick_req(TIME_MAX));                 // all sixteen due

        // random: mostly a clock moving forward with short timers
        sim_now = '0;
        timer_reqs.push_back(tick_req(sim_now));
        while (timer_reqs.size() < 25 + N_RANDOM) begin
            roll = $urandom_range(0, 99);
            if (roll < 52) begin
                timer_reqs.push_back(sched_req(DELAY_W'($urandom_range(0, 40)), rand_handle()));
            end else if (roll < 77) begin
                sim_now = sim_now + TIME_W'($urandom_range(0, 30000));
                timer_reqs.push_back(tick_req(sim_now));
            end else if (roll < 81) begin
                timer_reqs.push_back(tick_req(sim_now - TIME_W'($urandom_range(0, 20000))));
            end else if (roll < 86) begin
                timer_reqs.push_back(sched_req(rand_delay(), rand_handle()));
            end else if (roll < 89) begin
                sim_now = rand_time();
                timer_reqs.push_back(tick_req(sim_now));
            end else if (roll < 92) begin
                // drain everything, restart the clock low
                timer_reqs.push_back(tick_req(TIME_MAX));
                sim_now = TIME_W'($urandom_range(0, 1000000));
                timer_reqs.push_back(tick_req(sim_now));
            end else begin
                burst = $urandom_range(8, 20);
                for (int i = 0; i < burst; i++)
                    timer_reqs.push_back(sched_req(DELAY_W'($urandom_range(0, 30)),
                                                   rand_handle()));
            end
        end
        total_reqs = timer_reqs.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (timer_reqs.size() == 0 && accepted_cnt == total_reqs);
        draining = 1'b1;
        wait (due_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && due_words.size() == 0)
            $display("deadline_timer_queue_tb OK");
        else
            $display("deadline_timer_queue_tb NOT OK");
        $finish;
    end

endmodule
